// ===== hw/rtl/triangle_brocard_point_core_defines.svh =====
// ----------------------------------------------------------------------------
// triangle brocard point assertion macros
// shared property forms for the checker of the brocard point core
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BROCARD_POINT_CORE_DEFINES_SVH
`define TRIANGLE_BROCARD_POINT_CORE_DEFINES_SVH

// antecedent holds at this edge, consequent at the same edge
`define TBP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tbp check failed");

// antecedent holds at this edge, consequent at the next edge
`define TBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tbp check failed");

`endif

// ===== hw/rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// widths and types shared by the brocard point core and its channels
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int DIG_W  = 32;   // multiplier digit
    localparam int IN_W   = 32;   // vertex coordinate
    localparam int OUT_W  = 48;   // result coordinate
    localparam int DIF_W  = 33;   // vertex difference
    localparam int SQ_W   = 66;   // squared side length
    localparam int PR_W   = 132;  // product of two squared sides and their sum
    localparam int NUM_W  = 166;  // numerator of the quotient
    localparam int DIV_W  = PR_W + 1;
    localparam int REM_W  = 172;  // offset numerator and remainder
    localparam int Q_W    = 38;   // offset quotient bits
    localparam int QOFF_W = 36;   // quotient offset exponent
    localparam int RND_SH = QOFF_W + 1;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic                    degenerate;
    } t_res;

endpackage

// ===== hw/rtl/tbp_if.sv =====
// ----------------------------------------------------------------------------
// tbp channels
// triangle input channel and brocard point output channel
// ----------------------------------------------------------------------------
interface tbp_in_if import tbp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] vertex_a_x;
    logic signed [IN_W-1:0] vertex_a_y;
    logic signed [IN_W-1:0] vertex_b_x;
    logic signed [IN_W-1:0] vertex_b_y;
    logic signed [IN_W-1:0] vertex_c_x;
    logic signed [IN_W-1:0] vertex_c_y;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        output ready
    );
endinterface

interface tbp_out_if import tbp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic                    degenerate;

    modport source (output valid, point_x, point_y, degenerate, input ready);
    modport sink (input valid, point_x, point_y, degenerate, output ready);
endinterface

// ===== hw/rtl/tbp_mul.sv =====
// ----------------------------------------------------------------------------
// tbp_mul
// pipelined sign-magnitude multiplier, one digit product per stage
// ----------------------------------------------------------------------------
module tbp_mul import tbp_pkg::*; #(
    parameter int AW = DIF_W,
    parameter int BW = DIF_W,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    input  logic                 i_neg,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [AW+BW:0] o_prod,
    output logic [SW-1:0]        o_side
);

    localparam int NA  = (AW + DIG_W - 1) / DIG_W;
    localparam int NB  = (BW + DIG_W - 1) / DIG_W;
    localparam int NS  = NA * NB;
    localparam int AWP = NA * DIG_W;
    localparam int BWP = NB * DIG_W;
    localparam int AP  = AWP + BWP;
    localparam int PW  = AW + BW + 1;

    logic [AWP-1:0] r_a    [0:NS-1];
    logic [BWP-1:0] r_b    [0:NS-1];
    logic [AP-1:0]  r_acc  [0:NS-1];
    logic           r_neg  [0:NS-1];
    logic [SW-1:0]  r_side [0:NS-1];
    logic           r_vld  [0:NS-1];

    logic signed [PW-1:0] w_mag;
    logic signed [PW-1:0] r_prod;
    logic [SW-1:0]        r_oside;
    logic                 r_ovld;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int I = k % NA;
        localparam int J = k / NA;

        logic [AWP-1:0]     w_a;
        logic [BWP-1:0]     w_b;
        logic [AP-1:0]      w_acc;
        logic               w_neg;
        logic [SW-1:0]      w_side;
        logic               w_vld;
        logic [2*DIG_W-1:0] w_pp;

        if (k == 0) begin : g_first
            assign w_a    = AWP'(i_a);
            assign w_b    = BWP'(i_b);
            assign w_acc  = '0;
            assign w_neg  = i_neg;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_a    = r_a[k-1];
            assign w_b    = r_b[k-1];
            assign w_acc  = r_acc[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_pp = w_a[I*DIG_W +: DIG_W] * w_b[J*DIG_W +: DIG_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]    <= w_a;
                r_b[k]    <= w_b;
                r_acc[k]  <= w_acc + (AP'(w_pp) << ((I + J) * DIG_W));
                r_neg[k]  <= w_neg;
                r_side[k] <= w_side;
            end
        end
    end

    assign w_mag = PW'(r_acc[NS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= r_neg[NS-1] ? -w_mag : w_mag;
            r_oside <= r_side[NS-1];
        end
    end

    assign o_valid = r_ovld;
    assign o_prod  = r_prod;
    assign o_side  = r_oside;

endmodule

// ===== hw/rtl/triangle_brocard_point_core.sv =====
// ----------------------------------------------------------------------------
// triangle_brocard_point_core
// first brocard point of a triangle given in signed fixed point
// ----------------------------------------------------------------------------
// Takes one triangle per cycle unless stalled and returns its first Brocard
// point: squared sides, their pairwise products and the weighted numerator
// run through digit-serial multiplier pipelines (32x32 per stage), and the
// rounded quotient comes from a 38-stage restoring divider, one quotient bit
// per stage. The pipeline stalls only when the two-entry output buffer is
// full. A triangle of zero area returns the origin with the degenerate flag
// set.
module triangle_brocard_point_core import tbp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbp_in_if.sink    i_tri,
    tbp_out_if.source o_pnt
);

    typedef struct packed {
        logic signed [IN_W-1:0]  ax;
        logic signed [IN_W-1:0]  ay;
        logic signed [DIF_W-1:0] ux;
        logic signed [DIF_W-1:0] uy;
        logic signed [DIF_W-1:0] vx;
        logic signed [DIF_W-1:0] vy;
    } t_s1;

    typedef struct packed {
        t_s1  base;
        logic deg;
    } t_s3;

    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic [PR_W-1:0]        s;
        logic                   deg;
    } t_s5;

    localparam int S1_W = $bits(t_s1);
    localparam int S3_W = $bits(t_s3);
    localparam int S5_W = $bits(t_s5);

    function automatic logic [DIF_W-1:0] f_mag(input logic signed [DIF_W-1:0] x);
        return x[DIF_W-1] ? DIF_W'(-x) : DIF_W'(x);
    endfunction

    logic w_en;

    // ---------------- difference stage ----------------
    logic                    r0_vld;
    t_s1                     r0_s;
    logic signed [DIF_W-1:0] r0_wx;
    logic signed [DIF_W-1:0] r0_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_tri.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_s.ax <= i_tri.vertex_a_x;
            r0_s.ay <= i_tri.vertex_a_y;
            r0_s.ux <= DIF_W'(i_tri.vertex_b_x) - DIF_W'(i_tri.vertex_a_x);
            r0_s.uy <= DIF_W'(i_tri.vertex_b_y) - DIF_W'(i_tri.vertex_a_y);
            r0_s.vx <= DIF_W'(i_tri.vertex_c_x) - DIF_W'(i_tri.vertex_a_x);
            r0_s.vy <= DIF_W'(i_tri.vertex_c_y) - DIF_W'(i_tri.vertex_a_y);
            r0_wx   <= DIF_W'(i_tri.vertex_c_x) - DIF_W'(i_tri.vertex_b_x);
            r0_wy   <= DIF_W'(i_tri.vertex_c_y) - DIF_W'(i_tri.vertex_b_y);
        end
    end

    // ---------------- cross product and squares ----------------
    localparam int P1_W = 2 * DIF_W + 1;

    logic                   w1_vld;
    logic [S1_W-1:0]        w1_side;
    logic signed [P1_W-1:0] w_cr0, w_cr1;
    logic signed [P1_W-1:0] w_sq_ux, w_sq_uy, w_sq_vx, w_sq_vy, w_sq_wx, w_sq_wy;

    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(S1_W)) u_mul_cr0 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_s.ux)), .i_b(f_mag(r0_s.vy)),
        .i_neg(r0_s.ux[DIF_W-1] ^ r0_s.vy[DIF_W-1]), .i_side(r0_s),
        .o_valid(w1_vld), .o_prod(w_cr0), .o_side(w1_side)
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_cr1 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_s.uy)), .i_b(f_mag(r0_s.vx)),
        .i_neg(r0_s.uy[DIF_W-1] ^ r0_s.vx[DIF_W-1]), .i_side(1'b0),
        .o_valid(), .o_prod(w_cr1), .o_side()
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_sq_ux (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_s.ux)), .i_b(f_mag(r0_s.ux)), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_sq_ux), .o_side()
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_sq_uy (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_s.uy)), .i_b(f_mag(r0_s.uy)), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_sq_uy), .o_side()
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_sq_vx (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_s.vx)), .i_b(f_mag(r0_s.vx)), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_sq_vx), .o_side()
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_sq_vy (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_s.vy)), .i_b(f_mag(r0_s.vy)), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_sq_vy), .o_side()
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_sq_wx (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_wx)), .i_b(f_mag(r0_wx)), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_sq_wx), .o_side()
    );
    tbp_mul #(.AW(DIF_W), .BW(DIF_W), .SW(1)) u_mul_sq_wy (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_vld),
        .i_a(f_mag(r0_wy)), .i_b(f_mag(r0_wy)), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_sq_wy), .o_side()
    );

    // ---------------- squared sides ----------------
    logic            r2_vld;
    t_s3             r2_s;
    logic [SQ_W-1:0] r2_c2, r2_b2, r2_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= w1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_s.base <= t_s1'(w1_side);
            // zero area when both cross terms agree
            r2_s.deg  <= (w_cr0 == w_cr1);
            r2_c2     <= SQ_W'(w_sq_ux) + SQ_W'(w_sq_uy);
            r2_b2     <= SQ_W'(w_sq_vx) + SQ_W'(w_sq_vy);
            r2_a2     <= SQ_W'(w_sq_wx) + SQ_W'(w_sq_wy);
        end
    end

    // ---------------- side weights ----------------
    localparam int P3_W = 2 * SQ_W + 1;

    logic                   w3_vld;
    logic [S3_W-1:0]        w3_side;
    logic signed [P3_W-1:0] w_wb, w_wc, w_ca;

    tbp_mul #(.AW(SQ_W), .BW(SQ_W), .SW(S3_W)) u_mul_wb (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r2_vld),
        .i_a(r2_a2), .i_b(r2_b2), .i_neg(1'b0), .i_side(r2_s),
        .o_valid(w3_vld), .o_prod(w_wb), .o_side(w3_side)
    );
    tbp_mul #(.AW(SQ_W), .BW(SQ_W), .SW(1)) u_mul_wc (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r2_vld),
        .i_a(r2_b2), .i_b(r2_c2), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_wc), .o_side()
    );
    tbp_mul #(.AW(SQ_W), .BW(SQ_W), .SW(1)) u_mul_ca (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r2_vld),
        .i_a(r2_c2), .i_b(r2_a2), .i_neg(1'b0), .i_side(1'b0),
        .o_valid(), .o_prod(w_ca), .o_side()
    );

    logic            r4_vld;
    t_s3             r4_s;
    logic [PR_W-1:0] r4_wb, r4_wc, r4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= w3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_s   <= t_s3'(w3_side);
            r4_wb  <= PR_W'(w_wb);
            r4_wc  <= PR_W'(w_wc);
            r4_sum <= PR_W'(w_ca) + PR_W'(w_wb) + PR_W'(w_wc);
        end
    end

    // ---------------- weighted numerators ----------------
    t_s5                     w4_side;
    logic                    w5_vld;
    logic [S5_W-1:0]         w5_side;
    logic signed [NUM_W-1:0] w_nbx, w_ncx, w_nby, w_ncy;

    assign w4_side.ax  = r4_s.base.ax;
    assign w4_side.ay  = r4_s.base.ay;
    assign w4_side.s   = r4_sum;
    assign w4_side.deg = r4_s.deg;

    tbp_mul #(.AW(PR_W), .BW(DIF_W), .SW(S5_W)) u_mul_nbx (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4_vld),
        .i_a(r4_wb), .i_b(f_mag(r4_s.base.ux)), .i_neg(r4_s.base.ux[DIF_W-1]),
        .i_side(w4_side), .o_valid(w5_vld), .o_prod(w_nbx), .o_side(w5_side)
    );
    tbp_mul #(.AW(PR_W), .BW(DIF_W), .SW(1)) u_mul_ncx (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4_vld),
        .i_a(r4_wc), .i_b(f_mag(r4_s.base.vx)), .i_neg(r4_s.base.vx[DIF_W-1]),
        .i_side(1'b0), .o_valid(), .o_prod(w_ncx), .o_side()
    );
    tbp_mul #(.AW(PR_W), .BW(DIF_W), .SW(1)) u_mul_nby (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4_vld),
        .i_a(r4_wb), .i_b(f_mag(r4_s.base.uy)), .i_neg(r4_s.base.uy[DIF_W-1]),
        .i_side(1'b0), .o_valid(), .o_prod(w_nby), .o_side()
    );
    tbp_mul #(.AW(PR_W), .BW(DIF_W), .SW(1)) u_mul_ncy (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4_vld),
        .i_a(r4_wc), .i_b(f_mag(r4_s.base.vy)), .i_neg(r4_s.base.vy[DIF_W-1]),
        .i_side(1'b0), .o_valid(), .o_prod(w_ncy), .o_side()
    );

    t_s5                     w5_s;
    logic                    r6_vld;
    logic signed [NUM_W-1:0] r6_nx, r6_ny;
    logic [REM_W-1:0]        r6_off;
    logic [DIV_W-1:0]        r6_d;
    logic signed [IN_W-1:0]  r6_ax, r6_ay;
    logic                    r6_deg;

    assign w5_s = t_s5'(w5_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= w5_vld;
        end
    end

    // round half up as floor((2n + s) / 2s), offset by 2^36 quotients to stay positive
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_nx  <= w_nbx + w_ncx;
            r6_ny  <= w_nby + w_ncy;
            r6_off <= REM_W'(w5_s.s) + (REM_W'(w5_s.s) << RND_SH);
            r6_d   <= {w5_s.s, 1'b0};
            r6_ax  <= w5_s.ax;
            r6_ay  <= w5_s.ay;
            r6_deg <= w5_s.deg;
        end
    end

    logic                   r7_vld;
    logic [REM_W-1:0]       r7_mx, r7_my;
    logic [DIV_W-1:0]       r7_d;
    logic signed [IN_W-1:0] r7_ax, r7_ay;
    logic                   r7_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_mx  <= (REM_W'(r6_nx) << 1) + r6_off;
            r7_my  <= (REM_W'(r6_ny) << 1) + r6_off;
            r7_d   <= r6_d;
            r7_ax  <= r6_ax;
            r7_ay  <= r6_ay;
            r7_deg <= r6_deg;
        end
    end

    // ---------------- restoring divider, msb first ----------------
    logic                   r_dv_vld [0:Q_W-1];
    logic [REM_W-1:0]       r_dv_rx  [0:Q_W-1];
    logic [REM_W-1:0]       r_dv_ry  [0:Q_W-1];
    logic [Q_W-1:0]         r_dv_qx  [0:Q_W-1];
    logic [Q_W-1:0]         r_dv_qy  [0:Q_W-1];
    logic [DIV_W-1:0]       r_dv_d   [0:Q_W-1];
    logic signed [IN_W-1:0] r_dv_ax  [0:Q_W-1];
    logic signed [IN_W-1:0] r_dv_ay  [0:Q_W-1];
    logic                   r_dv_deg [0:Q_W-1];

    for (genvar t = 0; t < Q_W; t++) begin : g_div
        localparam int B = Q_W - 1 - t;

        logic                   w_vld;
        logic [REM_W-1:0]       w_rx, w_ry, w_trial;
        logic [Q_W-1:0]         w_qx, w_qy;
        logic [DIV_W-1:0]       w_d;
        logic signed [IN_W-1:0] w_ax, w_ay;
        logic                   w_deg;
        logic                   w_gex, w_gey;

        if (t == 0) begin : g_first
            assign w_vld = r7_vld;
            assign w_rx  = r7_mx;
            assign w_ry  = r7_my;
            assign w_qx  = '0;
            assign w_qy  = '0;
            assign w_d   = r7_d;
            assign w_ax  = r7_ax;
            assign w_ay  = r7_ay;
            assign w_deg = r7_deg;
        end else begin : g_next
            assign w_vld = r_dv_vld[t-1];
            assign w_rx  = r_dv_rx[t-1];
            assign w_ry  = r_dv_ry[t-1];
            assign w_qx  = r_dv_qx[t-1];
            assign w_qy  = r_dv_qy[t-1];
            assign w_d   = r_dv_d[t-1];
            assign w_ax  = r_dv_ax[t-1];
            assign w_ay  = r_dv_ay[t-1];
            assign w_deg = r_dv_deg[t-1];
        end

        assign w_trial = REM_W'(w_d) << B;
        assign w_gex   = (w_rx >= w_trial);
        assign w_gey   = (w_ry >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[t] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[t] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rx[t]  <= w_gex ? w_rx - w_trial : w_rx;
                r_dv_ry[t]  <= w_gey ? w_ry - w_trial : w_ry;
                r_dv_qx[t]  <= w_qx | (Q_W'(w_gex) << B);
                r_dv_qy[t]  <= w_qy | (Q_W'(w_gey) << B);
                r_dv_d[t]   <= w_d;
                r_dv_ax[t]  <= w_ax;
                r_dv_ay[t]  <= w_ay;
                r_dv_deg[t] <= w_deg;
            end
        end
    end

    // ---------------- result and output buffer ----------------
    // the point lies inside the triangle, so the sum always fits the output range
    t_res       w_res;
    t_res       r_fifo [0:1];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    always_comb begin
        w_res.degenerate = r_dv_deg[Q_W-1];
        if (r_dv_deg[Q_W-1]) begin
            w_res.point_x = '0;
            w_res.point_y = '0;
        end else begin
            w_res.point_x = OUT_W'(r_dv_ax[Q_W-1]) + OUT_W'(r_dv_qx[Q_W-1])
                          - (OUT_W'(1) << QOFF_W);
            w_res.point_y = OUT_W'(r_dv_ay[Q_W-1]) + OUT_W'(r_dv_qy[Q_W-1])
                          - (OUT_W'(1) << QOFF_W);
        end
    end

    assign w_en   = (r_cnt != 2'd2);
    assign w_push = w_en & r_dv_vld[Q_W-1];
    assign w_pop  = o_pnt.valid & o_pnt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr] <= w_res;
        end
    end

    assign i_tri.ready      = w_en;
    assign o_pnt.valid      = (r_cnt != 2'd0);
    assign o_pnt.point_x    = r_fifo[r_rd].point_x;
    assign o_pnt.point_y    = r_fifo[r_rd].point_y;
    assign o_pnt.degenerate = r_fifo[r_rd].degenerate;

endmodule

// ===== hw/rtl/tbp_chk.sv =====
// ----------------------------------------------------------------------------
// tbp_chk
// port-level checks for the brocard point core
// ----------------------------------------------------------------------------
`include "triangle_brocard_point_core_defines.svh"

module tbp_chk import tbp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] i_point_x,
    input logic signed [OUT_W-1:0] i_point_y,
    input logic                    i_degenerate
);

    // a stalled result stays put until its transfer
    `TBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_point_x) && $stable(i_point_y) && $stable(i_degenerate))

    // zero-area triangles give the origin
    `TBP_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, i_out_valid && i_degenerate, i_point_x == '0 && i_point_y == '0)

    // input back-pressure only with results waiting
    `TBP_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // a result transfer frees room for the next triangle
    `TBP_ASSERT_NEXT(a_stall_clear, i_clk, i_rst_n, i_out_valid && i_out_ready, i_in_ready)

endmodule

bind triangle_brocard_point_core tbp_chk u_tbp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_tri.ready),
    .i_out_valid  (o_pnt.valid),
    .i_out_ready  (o_pnt.ready),
    .i_point_x    (o_pnt.point_x),
    .i_point_y    (o_pnt.point_y),
    .i_degenerate (o_pnt.degenerate)
);
